// File: rtl/core/dep_pkg.sv
// ---------------------------------------------------------------------------
// Decimal entry parser package
// Shared constants and codes for the decimal entry parser core and checker.
// ---------------------------------------------------------------------------
`default_nettype none

package dep_pkg;

   localparam int CHAR_WIDTH      = 8;
   localparam int VALUE_WIDTH     = 32;
   localparam int COUNT_WIDTH     = 32;
   localparam int CSR_INDEX_WIDTH = 1;

   localparam logic [CHAR_WIDTH-1:0] ASCII_ZERO       = 8'h30;
   localparam logic [CHAR_WIDTH-1:0] ASCII_NINE       = 8'h39;
   localparam logic [CHAR_WIDTH-1:0] END_CHAR_RESET   = 8'd13;
   localparam logic [CHAR_WIDTH-1:0] ERASE_CHAR_RESET = 8'd127;

   // Reciprocal of ten scaled by 2^35; exact quotient for every 32-bit value.
   localparam logic [VALUE_WIDTH-1:0] RECIP_TEN  = 32'hCCCC_CCCD;
   localparam int                     RECIP_SHIFT = 35;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_END_CHAR   = 1'b0,
      CSR_ERASE_CHAR = 1'b1
   } csr_index_type;

   typedef enum logic {
      KIND_ECHO   = 1'b0,
      KIND_NUMBER = 1'b1
   } result_kind_type;

endpackage

`default_nettype wire

// File: rtl/core/decimal_entry_parser_core.sv
// A result word is registered and appears on rsp_valid in the cycle after its character is accepted.
// Throughput: one character per cycle while req_stall is low; the value*10 update and
// the reciprocal divide by ten are both combinational and load the value register on accept.
// req_stall rises only while a result word is held and rsp_stall is high.
// Reset (synchronous) clears value, digit count, overflow flag and the result
// valid flag, and returns end_char to 13 and erase_char to 127.
// ---------------------------------------------------------------------------
// Decimal entry parser core
// Builds an unsigned 32-bit number from received decimal digit characters,
// with erase and end characters, echoing accepted digit and erase characters.
// ---------------------------------------------------------------------------
`default_nettype none

module decimal_entry_parser_core (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // Input channel
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic [dep_pkg::CHAR_WIDTH-1:0]        req_rx_char,
   // Result channel
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic                                       rsp_result_kind,
   output logic [dep_pkg::CHAR_WIDTH-1:0]             rsp_echo_char,
   output logic [dep_pkg::VALUE_WIDTH-1:0]            rsp_number,
   output logic                                       rsp_overflowed,
   // Configuration port
   input  wire logic                                  csr_write_enable,
   input  wire logic [dep_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  wire logic [dep_pkg::CHAR_WIDTH-1:0]        csr_write_data
);

   localparam int WIDE_WIDTH = dep_pkg::VALUE_WIDTH + 4;
   localparam int PROD_WIDTH = 2 * dep_pkg::VALUE_WIDTH;

   logic [dep_pkg::CHAR_WIDTH-1:0]  end_char_ff, end_char_in;
   logic [dep_pkg::CHAR_WIDTH-1:0]  erase_char_ff, erase_char_in;
   logic [dep_pkg::VALUE_WIDTH-1:0] value_ff, value_in;
   logic [dep_pkg::COUNT_WIDTH-1:0] count_ff, count_in;
   logic                            ovf_ff, ovf_in;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic                            rsp_kind_ff, rsp_kind_in;
   logic [dep_pkg::CHAR_WIDTH-1:0]  rsp_echo_ff, rsp_echo_in;
   logic [dep_pkg::VALUE_WIDTH-1:0] rsp_number_ff, rsp_number_in;
   logic                            rsp_ovf_ff, rsp_ovf_in;

   logic                            accept;
   logic                            is_end;
   logic                            is_digit;
   logic                            is_erase;
   logic                            has_result;
   logic [WIDE_WIDTH-1:0]           times_ten;
   logic [PROD_WIDTH-1:0]           recip_prod;
   logic [dep_pkg::VALUE_WIDTH-1:0] div_ten;
   logic [dep_pkg::CHAR_WIDTH-1:0]  digit;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   // Character classification; the end character takes priority, then digits.
   always_comb begin
      is_end   = (req_rx_char == end_char_ff);
      is_digit = ~is_end && (req_rx_char >= dep_pkg::ASCII_ZERO)
                         && (req_rx_char <= dep_pkg::ASCII_NINE);
      is_erase = ~is_end && ~is_digit && (req_rx_char == erase_char_ff)
                         && (count_ff != '0);
      has_result = is_end | is_digit | is_erase;
   end

   // value*10 + digit as shift-and-add, kept wide enough to see the wrap.
   always_comb begin
      digit     = req_rx_char - dep_pkg::ASCII_ZERO;
      times_ten = ({4'b0, value_ff} << 3) + ({4'b0, value_ff} << 1)
                + {{(WIDE_WIDTH-dep_pkg::CHAR_WIDTH){1'b0}}, digit};
   end

   // Division by ten through the scaled reciprocal.
   always_comb begin
      recip_prod = {{dep_pkg::VALUE_WIDTH{1'b0}}, value_ff}
                 * {{dep_pkg::VALUE_WIDTH{1'b0}}, dep_pkg::RECIP_TEN};
      div_ten    = dep_pkg::VALUE_WIDTH'(recip_prod >> dep_pkg::RECIP_SHIFT);
   end

   always_comb begin
      value_in = value_ff;
      count_in = count_ff;
      ovf_in   = ovf_ff;
      if (accept) begin
         if (is_end) begin
            value_in = '0;
            count_in = '0;
            ovf_in   = 1'b0;
         end else if (is_digit) begin
            value_in = times_ten[dep_pkg::VALUE_WIDTH-1:0];
            count_in = count_ff + 1'b1;
            ovf_in   = ovf_ff | (times_ten[WIDE_WIDTH-1:dep_pkg::VALUE_WIDTH] != '0);
         end else if (is_erase) begin
            value_in = div_ten;
            count_in = count_ff - 1'b1;
         end
      end
   end

   always_comb begin
      end_char_in   = end_char_ff;
      erase_char_in = erase_char_ff;
      if (csr_write_enable) begin
         case (csr_index)
            dep_pkg::CSR_END_CHAR:   end_char_in   = csr_write_data;
            dep_pkg::CSR_ERASE_CHAR: erase_char_in = csr_write_data;
            default: begin
            end
         endcase
      end
   end

   // Result register: loads a word on an accepted character that has a result, otherwise holds until taken.
   always_comb begin
      rsp_kind_in   = rsp_kind_ff;
      rsp_echo_in   = rsp_echo_ff;
      rsp_number_in = rsp_number_ff;
      rsp_ovf_in    = rsp_ovf_ff;
      if (accept) begin
         rsp_valid_in = has_result;
      end else if (~rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
      if (accept && has_result) begin
         if (is_end) begin
            rsp_kind_in   = dep_pkg::KIND_NUMBER;
            rsp_echo_in   = '0;
            rsp_number_in = value_ff;
            rsp_ovf_in    = ovf_ff;
         end else begin
            rsp_kind_in   = dep_pkg::KIND_ECHO;
            rsp_echo_in   = req_rx_char;
            rsp_number_in = '0;
            rsp_ovf_in    = ovf_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         end_char_ff   <= dep_pkg::END_CHAR_RESET;
         erase_char_ff <= dep_pkg::ERASE_CHAR_RESET;
         value_ff      <= '0;
         count_ff      <= '0;
         ovf_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         end_char_ff   <= end_char_in;
         erase_char_ff <= erase_char_in;
         value_ff      <= value_in;
         count_ff      <= count_in;
         ovf_ff        <= ovf_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_kind_ff   <= rsp_kind_in;
      rsp_echo_ff   <= rsp_echo_in;
      rsp_number_ff <= rsp_number_in;
      rsp_ovf_ff    <= rsp_ovf_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_kind = rsp_kind_ff;
   assign rsp_echo_char   = rsp_echo_ff;
   assign rsp_number      = rsp_number_ff;
   assign rsp_overflowed  = rsp_ovf_ff;

endmodule

`default_nettype wire

// File: rtl/core/dep_checker.sv
// ---------------------------------------------------------------------------
// Decimal entry parser checker
// Port-level assertions on the parser core, attached by bind.
// ---------------------------------------------------------------------------
`default_nettype none

module dep_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                req_stall,
   input wire logic                                rsp_valid,
   input wire logic                                rsp_stall,
   input wire logic                                rsp_result_kind,
   input wire logic [dep_pkg::CHAR_WIDTH-1:0]      rsp_echo_char,
   input wire logic [dep_pkg::VALUE_WIDTH-1:0]     rsp_number,
   input wire logic                                rsp_overflowed
);

   // The result register is empty straight after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word present after reset");

   // The input is held back only while a result word is waiting.
   assert property (@(posedge clock) disable iff (reset) req_stall |-> rsp_valid)
      else $error("input stalled with no result word pending");

   // An echo word carries no number.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_result_kind == dep_pkg::KIND_ECHO) |-> rsp_number == '0)
      else $error("echo word carries a number");

   // A finished-number word carries no echo character.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_result_kind == dep_pkg::KIND_NUMBER) |-> rsp_echo_char == '0)
      else $error("number word carries an echo character");

   // A stalled result word stays and does not change.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_result_kind)
         && $stable(rsp_echo_char) && $stable(rsp_number) && $stable(rsp_overflowed)))
      else $error("stalled result word changed");

endmodule

bind decimal_entry_parser_core dep_checker u_dep_checker (.*);

`default_nettype wire

// File: test/decimal_entry_parser_core_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Decimal entry parser core testbench
// Feeds character words through the input channel, predicts every echo and
// finished number in step with acceptance, and checks each result word in
// order. A short directed table comes first, then random entry sequences
// under several end and erase character settings, with random idling on
// both channels and one long hold-off on the result side.
// ---------------------------------------------------------------------------

module decimal_entry_parser_core_test;

   localparam int RADIX          = 10;
   localparam int MAX_GAP        = 13;
   localparam int HOLD_OFF_LONG  = 60;
   localparam int SETTLE_LIMIT   = 400;
   localparam int PHASE_ITEMS    = 205;
   localparam int PHASE_COUNT    = 6;

   typedef struct packed {
      dep_pkg::result_kind_type           kind;
      logic [dep_pkg::CHAR_WIDTH-1:0]     echo;
      logic [dep_pkg::VALUE_WIDTH-1:0]    number;
      logic                               overflowed;
   } entry_word_type;

   typedef enum { ROW_CHAR, ROW_SET_END, ROW_SET_ERASE } row_op_type;

   typedef struct {
      row_op_type                         op;
      logic [dep_pkg::CHAR_WIDTH-1:0]     code;
      bit                                 typed;
      bit                                 has_word;
      entry_word_type                     word;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic [dep_pkg::CHAR_WIDTH-1:0] req_rx_char;
   logic rsp_valid;
   logic rsp_stall;
   logic rsp_result_kind;
   logic [dep_pkg::CHAR_WIDTH-1:0] rsp_echo_char;
   logic [dep_pkg::VALUE_WIDTH-1:0] rsp_number;
   logic rsp_overflowed;
   logic csr_write_enable;
   dep_pkg::csr_index_type csr_index;
   logic [dep_pkg::CHAR_WIDTH-1:0] csr_write_data;

   // Shadow copy of the block's registers and entry state.
   logic [dep_pkg::CHAR_WIDTH-1:0]  shadow_end;
   logic [dep_pkg::CHAR_WIDTH-1:0]  shadow_erase;
   logic [dep_pkg::VALUE_WIDTH-1:0] shadow_value;
   logic [dep_pkg::COUNT_WIDTH-1:0] shadow_count;
   logic                            shadow_overflow;

   entry_word_type                  pending_words[$];
   logic [dep_pkg::CHAR_WIDTH-1:0]  phase_chars[$];
   int                              error_count = 0;
   bit                              quiet = 1'b0;
   bit                              hold_off_request = 1'b0;

   // Typed rows carry results that follow directly from reset or the extremes.
   stim_row_type directed_rows [27] = '{
      '{ROW_CHAR, dep_pkg::END_CHAR_RESET,   1'b1, 1'b1,
        '{dep_pkg::KIND_NUMBER, 8'h00, 32'd0, 1'b0}},
      '{ROW_CHAR, dep_pkg::ERASE_CHAR_RESET, 1'b1, 1'b0, '0},
      '{ROW_CHAR, 8'h30,                     1'b0, 1'b0, '0},
      '{ROW_CHAR, 8'h39,                     1'b0, 1'b0, '0},
      '{ROW_CHAR, dep_pkg::ERASE_CHAR_RESET, 1'b1, 1'b1,
        '{dep_pkg::KIND_ECHO, dep_pkg::ERASE_CHAR_RESET, 32'd0, 1'b0}},
      '{ROW_CHAR, dep_pkg::END_CHAR_RESET,   1'b1, 1'b1,
        '{dep_pkg::KIND_NUMBER, 8'h00, 32'd0, 1'b0}},
      '{ROW_CHAR, 8'h00,                     1'b1, 1'b0, '0},
      '{ROW_CHAR, 8'hFF,                     1'b1, 1'b0, '0},
      '{ROW_CHAR, 8'h2F,                     1'b1, 1'b0, '0},
      '{ROW_CHAR, 8'h3A,                     1'b1, 1'b0, '0},
      // The largest value that fits, then one more digit to wrap it.
      '{ROW_CHAR, 8'h34,                     1'b0, 1'b0, '0},
      '{ROW_CHAR, 8'h32,                     1'b0, 1'b0, '0},
      '{ROW_CHAR, 8'h39,                     1'b0, 1'b0, '0},
      '{ROW_CHAR, 8'h34,                     1'b0, 1'b0, '0},
      '{ROW_CHAR, 8'h39,                     1'b0, 1'b0, '0},
      '{ROW_CHAR, 8'h36,                     1'b0, 1'b0, '0},
      '{ROW_CHAR, 8'h37,                     1'b0, 1'b0, '0},
      '{ROW_CHAR, 8'h32,                     1'b0, 1'b0, '0},
      '{ROW_CHAR, 8'h39,                     1'b0, 1'b0, '0},
      '{ROW_CHAR, 8'h35,                     1'b0, 1'b0, '0},
      '{ROW_CHAR, 8'h36,                     1'b0, 1'b0, '0},
      '{ROW_CHAR, dep_pkg::ERASE_CHAR_RESET, 1'b0, 1'b0, '0},
      '{ROW_CHAR, dep_pkg::END_CHAR_RESET,   1'b0, 1'b0, '0},
      // Digits as end and erase characters.
      '{ROW_SET_END,   8'h35,                1'b0, 1'b0, '0},
      '{ROW_SET_ERASE, 8'h37,                1'b0, 1'b0, '0},
      '{ROW_CHAR, 8'h37,                     1'b0, 1'b0, '0},
      '{ROW_CHAR, 8'h35,                     1'b1, 1'b1,
        '{dep_pkg::KIND_NUMBER, 8'h00, 32'd7, 1'b0}}
   };

   decimal_entry_parser_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rx_char      (req_rx_char),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_kind  (rsp_result_kind),
      .rsp_echo_char    (rsp_echo_char),
      .rsp_number       (rsp_number),
      .rsp_overflowed   (rsp_overflowed),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #2_000_000;
      $display("status: fail");
      $finish;
   end

   // Advances the shadow entry state by one character and gives the word it causes.
   function automatic bit parse_char(input logic [dep_pkg::CHAR_WIDTH-1:0] c,
                                     output entry_word_type w);
      logic [dep_pkg::VALUE_WIDTH+3:0] wide;
      w = '{dep_pkg::KIND_ECHO, 8'h00, 32'd0, 1'b0};
      if (c == shadow_end) begin
         w.kind = dep_pkg::KIND_NUMBER;
         w.number = shadow_value;
         w.overflowed = shadow_overflow;
         shadow_value = '0;
         shadow_count = '0;
         shadow_overflow = 1'b0;
         return 1'b1;
      end
      if (c >= dep_pkg::ASCII_ZERO && c <= dep_pkg::ASCII_NINE) begin
         wide = {4'd0, shadow_value} * RADIX + (c - dep_pkg::ASCII_ZERO);
         if (wide[dep_pkg::VALUE_WIDTH+3:dep_pkg::VALUE_WIDTH] != 0)
            shadow_overflow = 1'b1;
         shadow_value = wide[dep_pkg::VALUE_WIDTH-1:0];
         shadow_count = shadow_count + 1;
         w.echo = c;
         w.overflowed = shadow_overflow;
         return 1'b1;
      end
      if (c == shadow_erase && shadow_count != 0) begin
         shadow_value = shadow_value / RADIX;
         shadow_count = shadow_count - 1;
         w.echo = c;
         w.overflowed = shadow_overflow;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // Offers one character word and records what it should cause once accepted.
   task automatic send_char(input logic [dep_pkg::CHAR_WIDTH-1:0] c, input bit typed,
                            input bit want_has, input entry_word_type want);
      int gap;
      bit has;
      entry_word_type w;
      gap = quiet ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_rx_char <= c;
      do @(posedge clock); while (!(req_valid && !req_stall));
      has = parse_char(c, w);
      if (typed) begin
         has = want_has;
         w = want;
      end
      if (has)
         pending_words.push_back(w);
   endtask

   // Lowers valid and waits for the block to drain before a register write.
   task automatic settle();
      int n;
      req_valid <= 1'b0;
      for (n = 0; n < SETTLE_LIMIT && pending_words.size() != 0; n++)
         @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_csr(input dep_pkg::csr_index_type idx,
                            input logic [dep_pkg::CHAR_WIDTH-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (idx == dep_pkg::CSR_END_CHAR)
         shadow_end = data;
      else
         shadow_erase = data;
      @(posedge clock);
   endtask

   // Mostly well-formed entries with stray erases and noise mixed in.
   task automatic build_entries(input int target);
      int len;
      int r;
      int i;
      phase_chars.delete();
      while (phase_chars.size() < target) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 13) : $urandom_range(0, 6);
         for (i = 0; i < len; i++) begin
            r = $urandom_range(0, 99);
            if (r < 8)
               phase_chars.push_back(dep_pkg::CHAR_WIDTH'($urandom_range(0, 255)));
            else if (r < 20)
               phase_chars.push_back(shadow_erase);
            phase_chars.push_back(dep_pkg::ASCII_ZERO
                                  + dep_pkg::CHAR_WIDTH'($urandom_range(0, 9)));
         end
         if ($urandom_range(0, 9) != 0)
            phase_chars.push_back(shadow_end);
      end
   endtask

   initial begin : receiver
      int hold;
      rsp_stall = 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            hold = HOLD_OFF_LONG;
         end else begin
            hold = quiet ? 0 : $urandom_range(0, MAX_GAP);
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   always @(posedge clock) begin : check_words
      entry_word_type w;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_words.size() == 0) begin
            $error("result word with nothing expected");
            error_count++;
         end else begin
            w = pending_words.pop_front();
            if (rsp_result_kind !== w.kind) begin
               $error("rsp_result_kind expected %0d actual %0d", w.kind, rsp_result_kind);
               error_count++;
            end
            if (rsp_echo_char !== w.echo) begin
               $error("rsp_echo_char expected %0h actual %0h", w.echo, rsp_echo_char);
               error_count++;
            end
            if (rsp_number !== w.number) begin
               $error("rsp_number expected %0h actual %0h", w.number, rsp_number);
               error_count++;
            end
            if (rsp_overflowed !== w.overflowed) begin
               $error("rsp_overflowed expected %0d actual %0d", w.overflowed, rsp_overflowed);
               error_count++;
            end
         end
      end
   end

   initial begin : stimulus
      logic [dep_pkg::CHAR_WIDTH-1:0] end_set [PHASE_COUNT];
      logic [dep_pkg::CHAR_WIDTH-1:0] erase_set [PHASE_COUNT];
      int p;
      end_set   = '{dep_pkg::END_CHAR_RESET, 8'h00, 8'hFF, 8'h35, 8'h08, 8'h00};
      erase_set = '{dep_pkg::ERASE_CHAR_RESET, 8'hFF, 8'h00, 8'h37, 8'h08, 8'h00};
      reset = 1'b1;
      req_valid = 1'b0;
      req_rx_char = '0;
      csr_write_enable = 1'b0;
      csr_index = dep_pkg::CSR_END_CHAR;
      csr_write_data = '0;
      shadow_end = dep_pkg::END_CHAR_RESET;
      shadow_erase = dep_pkg::ERASE_CHAR_RESET;
      shadow_value = '0;
      shadow_count = '0;
      shadow_overflow = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         case (directed_rows[i].op)
            ROW_CHAR: begin
               send_char(directed_rows[i].code, directed_rows[i].typed,
                         directed_rows[i].has_word, directed_rows[i].word);
            end
            ROW_SET_END: begin
               settle();
               write_csr(dep_pkg::CSR_END_CHAR, directed_rows[i].code);
            end
            default: begin
               settle();
               write_csr(dep_pkg::CSR_ERASE_CHAR, directed_rows[i].code);
            end
         endcase
      end

      // The last setting is drawn at random.
      end_set[PHASE_COUNT-1] = dep_pkg::CHAR_WIDTH'($urandom_range(0, 255));
      erase_set[PHASE_COUNT-1] = dep_pkg::CHAR_WIDTH'($urandom_range(0, 255));
      for (p = 0; p < PHASE_COUNT; p++) begin
         settle();
         quiet = 1'b0;
         write_csr(dep_pkg::CSR_END_CHAR, end_set[p]);
         write_csr(dep_pkg::CSR_ERASE_CHAR, erase_set[p]);
         build_entries(PHASE_ITEMS);
         // Back-to-back words in phases 1 and 4; in phase 1 a long result hold-off fills the block.
         quiet = (p == 1) || (p == 4);
         if (p == 1)
            hold_off_request = 1'b1;
         foreach (phase_chars[k])
            send_char(phase_chars[k], 1'b0, 1'b0, '0);
      end

      settle();
      if (error_count == 0 && pending_words.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// File: decimal_entry_parser_core.f
rtl/core/dep_pkg.sv
rtl/core/decimal_entry_parser_core.sv
rtl/core/dep_checker.sv
test/decimal_entry_parser_core_test.sv
